// ===== hw/rtl/gpc_pkg.sv =====
// ----------------------------------------------------------------------------
// gpc_pkg
// Shared widths and parameter defaults for the grid path counter.
// ----------------------------------------------------------------------------
package gpc_pkg;

  // Field widths of the input and result words.
  localparam int ROWS_W  = 10;
  localparam int COLS_W  = 11;
  localparam int COUNT_W = 64;

  // Default grid limits.
  localparam int MAX_ROWS_DEF = 512;
  localparam int MAX_COLS_DEF = 1024;

endpackage

// ===== hw/rtl/gpc_row_mem.sv =====
// ----------------------------------------------------------------------------
// gpc_row_mem
// Row buffer: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gpc_row_mem #(
  parameter int DEPTH = gpc_pkg::MAX_COLS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [gpc_pkg::COUNT_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [gpc_pkg::COUNT_W-1:0] rd_data
);

  logic [gpc_pkg::COUNT_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, read data registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/gpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// gpc_ctrl
// Sequencer and adder: fills the row buffer with ones, then sweeps it
// row by row with a read, add and write-back pipeline when the grid is wider and taller than one.
// ----------------------------------------------------------------------------
module gpc_ctrl #(
  parameter int MAX_ROWS = gpc_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = gpc_pkg::MAX_COLS_DEF,
  parameter int AW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  // Input channel.
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [gpc_pkg::ROWS_W-1:0]  rows,
  input  logic [gpc_pkg::COLS_W-1:0]  cols,
  // Result channel.
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gpc_pkg::COUNT_W-1:0] path_count,
  // Row buffer.
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output logic [gpc_pkg::COUNT_W-1:0] wr_data,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  input  logic [gpc_pkg::COUNT_W-1:0] rd_data
);

  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int CW = $clog2(MAX_COLS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_CALC  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]                  state;
  logic [RW-1:0]               rows_q;
  logic [CW-1:0]               cols_q;
  logic [RW-1:0]               r;
  logic [CW-1:0]               c;
  logic [gpc_pkg::COUNT_W-1:0] left;
  logic [gpc_pkg::COUNT_W-1:0] result;

  // Read-to-write pipeline stage.
  logic                        v1;
  logic [AW-1:0]               a1;
  logic                        first1;
  logic                        last1;
  logic                        hit;
  logic [gpc_pkg::COUNT_W-1:0] hit_data;

  logic [31:0]                 rows_w;
  logic [31:0]                 cols_w;
  logic [RW-1:0]               rows_c;
  logic [CW-1:0]               cols_c;
  logic                        in_acc;
  logic                        out_free;
  logic                        col_last;
  logic                        row_last;
  logic [gpc_pkg::COUNT_W-1:0] above;
  logic [gpc_pkg::COUNT_W-1:0] sum;

  // Saturate the requested size to the grid limits.
  assign rows_w = 32'(rows);
  assign cols_w = 32'(cols);
  assign rows_c = (rows_w > 32'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(rows_w);
  assign cols_c = (cols_w > 32'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(cols_w);

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign col_last = (c == cols_q - CW'(1));
  assign row_last = (r == rows_q - RW'(1));

  // Take the entry just written when the read hit the same address.
  assign above = hit ? hit_data : rd_data;
  assign sum   = (first1 ? gpc_pkg::COUNT_W'(1) : left) + above;

  // Memory access: fill writes during the init pass, writes back sums later.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = c[AW-1:0];
    wr_data = gpc_pkg::COUNT_W'(1);
    if (state == ST_INIT) begin
      wr_en = 1'b1;
    end else if (v1) begin
      wr_en   = 1'b1;
      wr_addr = a1;
      wr_data = sum;
    end
    rd_en   = (state == ST_CALC);
    rd_addr = c[AW-1:0];
  end

  // Forwarding capture and the pipeline stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= rd_en;
    end
    hit      <= rd_en && wr_en && (rd_addr == wr_addr);
    hit_data <= wr_data;
    a1       <= rd_addr;
    first1   <= (c == CW'(1));
    last1    <= col_last && row_last;
    if (v1) begin
      left <= sum;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            rows_q <= rows_c;
            cols_q <= cols_c;
            c      <= '0;
            if (rows_c == '0 || cols_c == '0) begin
              result <= '0;
              state  <= ST_DONE;
            end else begin
              state <= ST_INIT;
            end
          end
        end
        ST_INIT: begin
          if (col_last) begin
            if (rows_q == RW'(1) || cols_q == CW'(1)) begin
              result <= gpc_pkg::COUNT_W'(1);
              state  <= ST_DONE;
            end else begin
              c     <= CW'(1);
              r     <= RW'(1);
              state <= ST_CALC;
            end
          end else begin
            c <= c + CW'(1);
          end
        end
        ST_CALC: begin
          if (col_last) begin
            c <= CW'(1);
            r <= r + RW'(1);
            if (row_last) begin
              state <= ST_DRAIN;
            end
          end else begin
            c <= c + CW'(1);
          end
        end
        ST_DRAIN: begin
          if (v1 && last1) begin
            result <= sum;
            state  <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      path_count <= result;
    end
  end

endmodule

// ===== hw/rtl/grid_path_count_top.sv =====
// Grid path counter: a rows by cols query is worked from acceptance to the result word
// by one read-add-write per table cell through the single row buffer port pair. An
// empty grid skips the fill pass, and a single row or a single column skips the sweep.
// One query is in work at a time; the next word is taken once the result word sits
// in the output register. Reset (rst, synchronous) clears the control state only.
// ----------------------------------------------------------------------------
// grid_path_count_top
// Counts monotone lattice paths across a grid, modulo 2^64.
// ----------------------------------------------------------------------------
module grid_path_count_top #(
  parameter int MAX_ROWS = gpc_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = gpc_pkg::MAX_COLS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [gpc_pkg::ROWS_W-1:0]  rows,
  input  logic [gpc_pkg::COLS_W-1:0]  cols,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gpc_pkg::COUNT_W-1:0] path_count
);

  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [gpc_pkg::COUNT_W-1:0] wr_data;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [gpc_pkg::COUNT_W-1:0] rd_data;

  // Sequencer and adder.
  gpc_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .AW       (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rows       (rows),
    .cols       (cols),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .path_count (path_count),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  // Row buffer.
  gpc_row_mem #(
    .DEPTH (MAX_COLS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ===== bench/grid_path_count_top_tb.sv =====
// ----------------------------------------------------------------------------
// grid_path_count_top_tb
// Self-checking bench for the grid path counter. A directed table covers
// empty grids, single rows and columns, saturated sizes, a wrapping count
// and one full-size grid. A mostly small-sized random run follows. Every
// accepted query word gets an expected count, from the table where it is known
// and from a software lattice walk otherwise, and every result word is compared in order against the oldest one.
// ----------------------------------------------------------------------------
module grid_path_count_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ROWS       = gpc_pkg::MAX_ROWS_DEF;
  localparam int MAX_COLS       = gpc_pkg::MAX_COLS_DEF;
  localparam int RANDOM_ITEMS   = 75;
  localparam int DRAIN_CYCLES   = 50;
  // Longer than any random query, so the block backs up behind the hold.
  localparam int HOLD_CYCLES    = 20_000;
  localparam int HOLD_AT_RESULT = 40;
  // The limit must cover a full-size grid, which runs with no handshake.
  localparam int WATCHDOG_LIMIT = 2_000_000;

  typedef struct packed {
    logic [gpc_pkg::ROWS_W-1:0]  rows;
    logic [gpc_pkg::COLS_W-1:0]  cols;
    logic                        known;
    logic [gpc_pkg::COUNT_W-1:0] count;
  } grid_case_t;

  localparam int N_DIRECTED = 25;
  localparam grid_case_t DIRECTED_CASES [N_DIRECTED] = '{
    '{10'd0,    11'd0,    1'b1, 64'd0},
    '{10'd0,    11'd1,    1'b1, 64'd0},
    '{10'd1,    11'd0,    1'b1, 64'd0},
    '{10'd1023, 11'd0,    1'b1, 64'd0},
    '{10'd0,    11'd2047, 1'b1, 64'd0},
    '{10'd1,    11'd1,    1'b1, 64'd1},
    '{10'd1,    11'd1024, 1'b1, 64'd1},
    '{10'd512,  11'd1,    1'b1, 64'd1},
    '{10'd1023, 11'd1,    1'b1, 64'd1},
    '{10'd1,    11'd2047, 1'b1, 64'd1},
    '{10'd2,    11'd2,    1'b1, 64'd2},
    '{10'd3,    11'd3,    1'b1, 64'd6},
    '{10'd2,    11'd1024, 1'b0, 64'd0},
    '{10'd2,    11'd2047, 1'b0, 64'd0},
    '{10'd1023, 11'd2,    1'b0, 64'd0},
    '{10'd513,  11'd3,    1'b0, 64'd0},
    '{10'd7,    11'd9,    1'b0, 64'd0},
    '{10'd40,   11'd40,   1'b0, 64'd0},
    '{10'd100,  11'd60,   1'b0, 64'd0},
    '{10'd682,  11'd2,    1'b0, 64'd0},
    '{10'd2,    11'd1365, 1'b0, 64'd0},
    '{10'd341,  11'd2,    1'b0, 64'd0},
    '{10'd3,    11'd682,  1'b0, 64'd0},
    '{10'd512,  11'd1024, 1'b0, 64'd0},
    '{10'd1,    11'd1,    1'b1, 64'd1}
  };

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [gpc_pkg::ROWS_W-1:0]  rows = '0;
  logic [gpc_pkg::COLS_W-1:0]  cols = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [gpc_pkg::COUNT_W-1:0] path_count;

  // Expected path counts, oldest first, and the predictor's row buffer.
  logic [gpc_pkg::COUNT_W-1:0] expected_counts [$];
  logic [gpc_pkg::COUNT_W-1:0] lattice_row [MAX_COLS];

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles  = 0;
  int unsigned burst_left   = 0;

  grid_path_count_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rows       (rows),
    .cols       (cols),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .path_count (path_count)
  );

  always #5 clk = ~clk;

  // Walk the lattice one row at a time, sums wrapping at 64 bits.
  function automatic logic [gpc_pkg::COUNT_W-1:0] count_lattice_paths(
      input logic [gpc_pkg::ROWS_W-1:0] grid_rows,
      input logic [gpc_pkg::COLS_W-1:0] grid_cols);
    int unsigned n_rows;
    int unsigned n_cols;
    n_rows = (grid_rows > MAX_ROWS) ? MAX_ROWS : grid_rows;
    n_cols = (grid_cols > MAX_COLS) ? MAX_COLS : grid_cols;
    if (n_rows == 0 || n_cols == 0)
      return '0;
    for (int c = 0; c < n_cols; c++)
      lattice_row[c] = 64'd1;
    for (int r = 1; r < n_rows; r++)
      for (int c = 1; c < n_cols; c++)
        lattice_row[c] = lattice_row[c] + lattice_row[c-1];
    return lattice_row[n_cols-1];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Offer one query word, with a random gap whenever a burst runs out.
  task automatic offer_grid(input logic [gpc_pkg::ROWS_W-1:0] grid_rows,
                            input logic [gpc_pkg::COLS_W-1:0] grid_cols,
                            input logic known,
                            input logic [gpc_pkg::COUNT_W-1:0] known_count);
    logic [gpc_pkg::COUNT_W-1:0] predicted;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    rows     <= grid_rows;
    cols     <= grid_cols;
    do @(posedge clk); while (in_stall);
    predicted = count_lattice_paths(grid_rows, grid_cols);
    expected_counts.push_back(known ? known_count : predicted);
  endtask

  // Receiver stall: a random mode, redrawn periodically from the stall counter, plus one long hold-off
  // so that the block backs up and stalls its input.
  int unsigned stall_cnt = 0;
  int unsigned hold_left = 0;
  int unsigned stall_mode = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 50 == 0)
      stall_mode <= $urandom_range(0, 2);
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen == HOLD_AT_RESULT) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      case (stall_mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= (stall_cnt % 7 == 2) || (stall_cnt % 7 == 3);
        end
        default: begin
          out_stall <= ($urandom_range(0, 2) == 0);
        end
      endcase
    end
  end

  // Result checker and watchdog.
  always @(posedge clk) begin
    logic [gpc_pkg::COUNT_W-1:0] want;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;

      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_counts.size() == 0) begin
          report_mismatch($sformatf("unexpected result word path_count=%0d", path_count));
        end else begin
          want = expected_counts.pop_front();
          if (path_count !== want)
            report_mismatch($sformatf("path_count got %0d want %0d", path_count, want));
        end
      end

      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TIMEOUT: no handshake for %0d cycles", idle_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Stimulus: directed table, then the random run, then drain.
  initial begin
    logic [gpc_pkg::ROWS_W-1:0] r;
    logic [gpc_pkg::COLS_W-1:0] c;
    int unsigned pick;

    rst <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++)
      offer_grid(DIRECTED_CASES[i].rows, DIRECTED_CASES[i].cols,
                 DIRECTED_CASES[i].known, DIRECTED_CASES[i].count);

    // Mostly small grids; tall, wide and empty shapes reach the high bits.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        r = gpc_pkg::ROWS_W'($urandom_range(1, 32));
        c = gpc_pkg::COLS_W'($urandom_range(1, 32));
      end else if (pick < 75) begin
        r = gpc_pkg::ROWS_W'($urandom_range(1, 64));
        c = gpc_pkg::COLS_W'($urandom_range(1, 128));
      end else if (pick < 85) begin
        r = gpc_pkg::ROWS_W'($urandom_range(0, 1023));
        c = gpc_pkg::COLS_W'($urandom_range(1, 3));
      end else if (pick < 95) begin
        r = gpc_pkg::ROWS_W'($urandom_range(1, 3));
        c = gpc_pkg::COLS_W'($urandom_range(0, 2047));
      end else if ($urandom_range(0, 1) == 0) begin
        r = '0;
        c = gpc_pkg::COLS_W'($urandom_range(0, 2047));
      end else begin
        r = gpc_pkg::ROWS_W'($urandom_range(0, 1023));
        c = '0;
      end
      offer_grid(r, c, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (expected_counts.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
